[rtl/core/pidc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidc_pkg
// shared types and constants of the clamped pid regulator
// ----------------------------------------------------------------------------
package pidc_pkg;

   // fixed register and state widths
   localparam int GAIN_WIDTH        = 16;
   localparam int DRIVE_LIMIT_WIDTH = 15;
   localparam int ACCUM_LIMIT_WIDTH = 31;
   localparam int ACCUM_WIDTH       = 32;

   // configuration port
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 32;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_GAIN_P      = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_GAIN_I      = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_GAIN_D      = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_DRIVE_LIMIT = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ACCUM_LIMIT = 3'd4;

   localparam logic [DRIVE_LIMIT_WIDTH-1:0] DRIVE_LIMIT_RESET = 15'h7FFF;
   localparam logic [ACCUM_LIMIT_WIDTH-1:0] ACCUM_LIMIT_RESET = 31'h7FFF_FFFF;

   // request operations
   localparam logic OP_COMPUTE = 1'b0;
   localparam logic OP_CLEAR   = 1'b1;

   // load strobes for the product and result stages
   typedef struct packed {
      logic prod_load;
      logic out_load;
   } mac_ctl_type;

endpackage

[rtl/core/pid_controller_clamped_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_controller_clamped_top
// positional pid regulator with integral clamp and output limit
// ----------------------------------------------------------------------------
// usage
//   req_* carries one request per handshake: tuser is the operation (compute
//   or clear), tdata holds target and feedback. rsp_* returns one result per
//   request: tdata holds the clamped drive, tuser the limiting flag.
//   csr_* writes the gains and limits by register index; writes are taken
//   every cycle and must only happen while no request is in flight.
// timing
//   four-stage pipeline: input register, integral update, gain products,
//   result register; a request passes through them in that order. one
//   request is taken every cycle while back-pressure does not hold the
//   pipeline; the integral add and clamp, in the integral stage, is the only loop.
// reset
//   synchronous, active high: empties the pipeline, zeroes the integral and
//   previous error, and returns the registers to their reset values.
// back-pressure
//   when rsp_tready is low the held result stays on rsp_tdata, earlier stages
//   keep filling their free slots, and req_tready drops only once all four
//   stages hold requests.
// ----------------------------------------------------------------------------
module pid_controller_clamped_top #(
   parameter int SAMPLE_WIDTH   = 16,
   parameter int GAIN_FRAC_BITS = 8
) (
   input  logic                                   clock,
   input  logic                                   reset,

   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]    req_tdata,  // target, feedback, zero pad
   input  logic                                   req_tuser,  // operation

   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]      rsp_tdata,  // drive, zero pad
   output logic                                   rsp_tuser,  // clamped

   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [pidc_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [pidc_pkg::CSR_DATA_WIDTH-1:0]    csr_data
);

   localparam int RSP_W = ((SAMPLE_WIDTH + 7) / 8) * 8;

   // configuration registers
   logic [pidc_pkg::GAIN_WIDTH-1:0]        gain_p_ff, gain_i_ff, gain_d_ff;
   logic [pidc_pkg::DRIVE_LIMIT_WIDTH-1:0] drive_limit_ff;
   logic [pidc_pkg::ACCUM_LIMIT_WIDTH-1:0] accum_limit_ff;

   // pipeline occupancy
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic s3_valid_ff, s3_valid_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic out_free, s3_free, s2_free, s1_free;
   logic s1_load, s2_load, s3_load, out_load;

   // input register
   logic                           s1_op_ff;
   logic signed [SAMPLE_WIDTH-1:0] s1_target_ff;
   logic signed [SAMPLE_WIDTH-1:0] s1_feedback_ff;

   // integral stage outputs
   logic                                    s2_op;
   logic signed [SAMPLE_WIDTH:0]            s2_err;
   logic signed [pidc_pkg::ACCUM_WIDTH-1:0] s2_accum;
   logic signed [SAMPLE_WIDTH+1:0]          s2_deriv;

   pidc_pkg::mac_ctl_type          mac_ctl;
   logic signed [SAMPLE_WIDTH-1:0] drive;
   logic                           clamped;

   // ---------------- configuration port ----------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff      <= '0;
         gain_i_ff      <= '0;
         gain_d_ff      <= '0;
         drive_limit_ff <= pidc_pkg::DRIVE_LIMIT_RESET;
         accum_limit_ff <= pidc_pkg::ACCUM_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            pidc_pkg::REG_GAIN_P: begin
               gain_p_ff <= csr_data[pidc_pkg::GAIN_WIDTH-1:0];
            end
            pidc_pkg::REG_GAIN_I: begin
               gain_i_ff <= csr_data[pidc_pkg::GAIN_WIDTH-1:0];
            end
            pidc_pkg::REG_GAIN_D: begin
               gain_d_ff <= csr_data[pidc_pkg::GAIN_WIDTH-1:0];
            end
            pidc_pkg::REG_DRIVE_LIMIT: begin
               drive_limit_ff <= csr_data[pidc_pkg::DRIVE_LIMIT_WIDTH-1:0];
            end
            pidc_pkg::REG_ACCUM_LIMIT: begin
               accum_limit_ff <= csr_data[pidc_pkg::ACCUM_LIMIT_WIDTH-1:0];
            end
            default: begin
               // unused index, write dropped
            end
         endcase
      end
   end

   // ---------------- pipeline flow ----------------
   // each stage advances when the stage after it is empty or moving
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign s3_free  = !s3_valid_ff || out_free;
   assign s2_free  = !s2_valid_ff || s3_free;
   assign s1_free  = !s1_valid_ff || s2_free;

   assign req_tready = s1_free;

   assign s1_load  = req_tvalid && s1_free;
   assign s2_load  = s1_valid_ff && s2_free;
   assign s3_load  = s2_valid_ff && s3_free;
   assign out_load = s3_valid_ff && out_free;

   assign s1_valid_in  = s1_load  ? 1'b1 : (s2_load  ? 1'b0 : s1_valid_ff);
   assign s2_valid_in  = s2_load  ? 1'b1 : (s3_load  ? 1'b0 : s2_valid_ff);
   assign s3_valid_in  = s3_load  ? 1'b1 : (out_load ? 1'b0 : s3_valid_ff);
   assign rsp_valid_in = out_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // input register, unpacks the request
   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_op_ff       <= req_tuser;
         s1_target_ff   <= req_tdata[SAMPLE_WIDTH-1:0];
         s1_feedback_ff <= req_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
      end
   end

   // ---------------- datapath ----------------
   pidc_integ #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_integ (
      .clock       (clock),
      .reset       (reset),
      .load        (s2_load),
      .op          (s1_op_ff),
      .target      (s1_target_ff),
      .feedback    (s1_feedback_ff),
      .accum_limit (accum_limit_ff),
      .op_out      (s2_op),
      .err_out     (s2_err),
      .accum_out   (s2_accum),
      .deriv_out   (s2_deriv)
   );

   assign mac_ctl.prod_load = s3_load;
   assign mac_ctl.out_load  = out_load;

   pidc_mac #(
      .SAMPLE_WIDTH   (SAMPLE_WIDTH),
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_mac (
      .clock       (clock),
      .ctl         (mac_ctl),
      .gain_p      (gain_p_ff),
      .gain_i      (gain_i_ff),
      .gain_d      (gain_d_ff),
      .drive_limit (drive_limit_ff),
      .op          (s2_op),
      .err         (s2_err),
      .accum       (s2_accum),
      .deriv       (s2_deriv),
      .drive       (drive),
      .clamped     (clamped)
   );

   // ---------------- result channel ----------------
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_W-SAMPLE_WIDTH){1'b0}}, drive};
   assign rsp_tuser  = clamped;

   // back-pressure only reaches the request side once every stage is occupied
   a_full_before_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (s1_valid_ff && s2_valid_ff && s3_valid_ff && rsp_valid_ff))
      else $error("request side stalled with a free pipeline slot");

endmodule

[rtl/core/pidc_integ.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidc_integ
// error, clamped integral and derivative stage; holds the regulator state
// ----------------------------------------------------------------------------
module pidc_integ #(
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          load,
   input  logic                                          op,
   input  logic signed [SAMPLE_WIDTH-1:0]                target,
   input  logic signed [SAMPLE_WIDTH-1:0]                feedback,
   input  logic [pidc_pkg::ACCUM_LIMIT_WIDTH-1:0]        accum_limit,
   output logic                                          op_out,
   output logic signed [SAMPLE_WIDTH:0]                  err_out,
   output logic signed [pidc_pkg::ACCUM_WIDTH-1:0]       accum_out,
   output logic signed [SAMPLE_WIDTH+1:0]                deriv_out
);

   localparam int EW = SAMPLE_WIDTH + 1;
   localparam int DW = SAMPLE_WIDTH + 2;
   localparam int AW = pidc_pkg::ACCUM_WIDTH;

   logic signed [AW-1:0] accum_ff, accum_in;
   logic signed [EW-1:0] last_error_ff, last_error_in;
   logic signed [DW-1:0] deriv_ff;
   logic                 op_ff;

   logic signed [EW-1:0] err;
   logic signed [AW:0]   acc_sum;
   logic signed [AW:0]   lim_pos;
   logic signed [AW:0]   lim_neg;
   logic signed [DW-1:0] deriv;

   assign err = {target[SAMPLE_WIDTH-1], target} - {feedback[SAMPLE_WIDTH-1], feedback};

   assign acc_sum = {accum_ff[AW-1], accum_ff} + {{(AW+1-EW){err[EW-1]}}, err};
   assign lim_pos = {{(AW+1-pidc_pkg::ACCUM_LIMIT_WIDTH){1'b0}}, accum_limit};
   assign lim_neg = -lim_pos;

   assign deriv = {err[EW-1], err} - {last_error_ff[EW-1], last_error_ff};

   always_comb begin
      accum_in      = accum_ff;
      last_error_in = last_error_ff;
      if (load) begin
         if (op == pidc_pkg::OP_CLEAR) begin
            accum_in      = '0;
            last_error_in = '0;
         end else begin
            last_error_in = err;
            if (acc_sum > lim_pos) begin
               accum_in = lim_pos[AW-1:0];
            end else if (acc_sum < lim_neg) begin
               accum_in = lim_neg[AW-1:0];
            end else begin
               accum_in = acc_sum[AW-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff      <= '0;
         last_error_ff <= '0;
      end else begin
         accum_ff      <= accum_in;
         last_error_ff <= last_error_in;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (load) begin
         deriv_ff <= deriv;
         op_ff    <= op;
      end
   end

   // the stored previous error is the current sample's error once loaded
   assign op_out    = op_ff;
   assign err_out   = last_error_ff;
   assign accum_out = accum_ff;
   assign deriv_out = deriv_ff;

   a_clear_zeroes: assert property (@(posedge clock) disable iff (reset)
      (load && op == pidc_pkg::OP_CLEAR) |=> (accum_ff == '0 && last_error_ff == '0))
      else $error("clear left integral or previous error nonzero");

   a_accum_bound: assert property (@(posedge clock) disable iff (reset)
      (load && op == pidc_pkg::OP_COMPUTE) |=>
         ($signed({accum_ff[AW-1], accum_ff}) <= $signed({2'b00, $past(accum_limit)}) &&
          $signed({accum_ff[AW-1], accum_ff}) >= -$signed({2'b00, $past(accum_limit)})))
      else $error("integral outside its limit after update");

endmodule

[rtl/core/pidc_mac.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidc_mac
// gain products, sum, fraction shift and output clamp
// ----------------------------------------------------------------------------
module pidc_mac #(
   parameter int SAMPLE_WIDTH   = 16,
   parameter int GAIN_FRAC_BITS = 8
) (
   input  logic                                          clock,
   input  pidc_pkg::mac_ctl_type                         ctl,
   input  logic [pidc_pkg::GAIN_WIDTH-1:0]               gain_p,
   input  logic [pidc_pkg::GAIN_WIDTH-1:0]               gain_i,
   input  logic [pidc_pkg::GAIN_WIDTH-1:0]               gain_d,
   input  logic [pidc_pkg::DRIVE_LIMIT_WIDTH-1:0]        drive_limit,
   input  logic                                          op,
   input  logic signed [SAMPLE_WIDTH:0]                  err,
   input  logic signed [pidc_pkg::ACCUM_WIDTH-1:0]       accum,
   input  logic signed [SAMPLE_WIDTH+1:0]                deriv,
   output logic signed [SAMPLE_WIDTH-1:0]                drive,
   output logic                                          clamped
);

   localparam int GW    = pidc_pkg::GAIN_WIDTH + 1;
   localparam int PW_P  = GW + SAMPLE_WIDTH + 1;
   localparam int PW_I  = GW + pidc_pkg::ACCUM_WIDTH;
   localparam int PW_D  = GW + SAMPLE_WIDTH + 2;
   localparam int MAXPW = (PW_I > PW_D) ? PW_I : PW_D;
   localparam int SUM_W = MAXPW + 2;
   localparam int LW    = pidc_pkg::DRIVE_LIMIT_WIDTH;

   logic signed [PW_P-1:0] prod_p, prod_p_ff;
   logic signed [PW_I-1:0] prod_i, prod_i_ff;
   logic signed [PW_D-1:0] prod_d, prod_d_ff;
   logic                   op_ff;

   logic signed [SUM_W-1:0] sum_all;
   logic signed [SUM_W-1:0] shifted;
   logic signed [SUM_W-1:0] lim_pos;
   logic signed [SUM_W-1:0] lim_neg;
   logic signed [SUM_W-1:0] limited;
   logic                    over;

   logic signed [SAMPLE_WIDTH-1:0] drive_ff, drive_in;
   logic                           clamped_ff, clamped_in;

   // gains are unsigned, so they enter with a zero sign bit
   assign prod_p = $signed({1'b0, gain_p}) * err;
   assign prod_i = $signed({1'b0, gain_i}) * accum;
   assign prod_d = $signed({1'b0, gain_d}) * deriv;

   always_ff @(posedge clock) begin
      if (ctl.prod_load) begin
         prod_p_ff <= prod_p;
         prod_i_ff <= prod_i;
         prod_d_ff <= prod_d;
         op_ff     <= op;
      end
   end

   assign sum_all = {{(SUM_W-PW_P){prod_p_ff[PW_P-1]}}, prod_p_ff}
                  + {{(SUM_W-PW_I){prod_i_ff[PW_I-1]}}, prod_i_ff}
                  + {{(SUM_W-PW_D){prod_d_ff[PW_D-1]}}, prod_d_ff};

   // arithmetic shift rounds toward minus infinity
   assign shifted = sum_all >>> GAIN_FRAC_BITS;

   assign lim_pos = {{(SUM_W-LW){1'b0}}, drive_limit};
   assign lim_neg = -lim_pos;

   always_comb begin
      limited = shifted;
      over    = 1'b0;
      if (shifted > lim_pos) begin
         limited = lim_pos;
         over    = 1'b1;
      end else if (shifted < lim_neg) begin
         limited = lim_neg;
         over    = 1'b1;
      end
   end

   always_comb begin
      if (op_ff == pidc_pkg::OP_CLEAR) begin
         drive_in   = '0;
         clamped_in = 1'b0;
      end else begin
         drive_in   = limited[SAMPLE_WIDTH-1:0];
         clamped_in = over;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.out_load) begin
         drive_ff   <= drive_in;
         clamped_ff <= clamped_in;
      end
   end

   assign drive   = drive_ff;
   assign clamped = clamped_ff;

   a_clear_result: assert property (@(posedge clock)
      (ctl.out_load && op_ff == pidc_pkg::OP_CLEAR) |=> (drive_ff == '0 && !clamped_ff))
      else $error("clear produced a nonzero result");

   a_zero_limit: assert property (@(posedge clock)
      (ctl.out_load && drive_limit == '0) |=> (drive_ff == '0))
      else $error("zero drive limit let a nonzero drive through");

endmodule

[tb/pid_controller_clamped_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_controller_clamped_checker
// watches the request, response and register channels of the clamped pid
// regulator, predicts every response and compares it field by field
// ----------------------------------------------------------------------------
module pid_controller_clamped_checker #(
   parameter int SAMPLE_WIDTH   = 16,
   parameter int GAIN_FRAC_BITS = 8
) (
   input  logic                                       clock,
   input  logic                                       reset,

   input  logic                                       req_tvalid,
   input  logic                                       req_tready,
   input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]        req_tdata,  // target, feedback, zero pad
   input  logic                                       req_tuser,  // operation

   input  logic                                       rsp_tvalid,
   input  logic                                       rsp_tready,
   input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]          rsp_tdata,  // drive, zero pad
   input  logic                                       rsp_tuser,  // clamped

   input  logic                                       csr_valid,
   input  logic                                       csr_ready,
   input  logic [pidc_pkg::CSR_INDEX_WIDTH-1:0]       csr_index,
   input  logic [pidc_pkg::CSR_DATA_WIDTH-1:0]        csr_data,

   output int                                         fail_count,
   output int                                         rsp_seen
);

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] drive;
      logic                           clamped;
   } drive_result_type;

   // shadow copy of the registers
   logic [pidc_pkg::GAIN_WIDTH-1:0]        kp, ki, kd;
   logic [pidc_pkg::DRIVE_LIMIT_WIDTH-1:0] out_lim;
   logic [pidc_pkg::ACCUM_LIMIT_WIDTH-1:0] integ_lim;

   // regulator state
   logic signed [pidc_pkg::ACCUM_WIDTH-1:0] integ;
   logic signed [SAMPLE_WIDTH:0]            prev_err;

   drive_result_type expected_drives[$];

   task automatic report_mismatch(input string what);
      $display("[%0t] pid check: %s", $time, what);
      fail_count++;
   endtask

   // one regulator step; updates the shadow state and queues the drive
   task automatic advance_regulator(input logic op,
                                    input logic signed [SAMPLE_WIDTH-1:0] tgt,
                                    input logic signed [SAMPLE_WIDTH-1:0] fb);
      longint err, acc, slope, total, lim_i, lim_o;
      drive_result_type res;
      res = '0;
      if (op == pidc_pkg::OP_CLEAR) begin
         integ    = '0;
         prev_err = '0;
      end else begin
         err   = longint'(tgt) - longint'(fb);
         lim_i = longint'(integ_lim);
         acc   = longint'(integ) + err;
         if (acc > lim_i)
            acc = lim_i;
         else if (acc < -lim_i)
            acc = -lim_i;
         slope    = err - longint'(prev_err);
         integ    = acc[pidc_pkg::ACCUM_WIDTH-1:0];
         prev_err = err[SAMPLE_WIDTH:0];
         total = longint'(kp) * err + longint'(ki) * acc + longint'(kd) * slope;
         // arithmetic shift floors toward minus infinity
         total = total >>> GAIN_FRAC_BITS;
         lim_o = longint'(out_lim);
         if (total > lim_o) begin
            total       = lim_o;
            res.clamped = 1'b1;
         end else if (total < -lim_o) begin
            total       = -lim_o;
            res.clamped = 1'b1;
         end
         res.drive = total[SAMPLE_WIDTH-1:0];
      end
      expected_drives.push_back(res);
   endtask

   always @(posedge clock) begin
      drive_result_type               want;
      logic signed [SAMPLE_WIDTH-1:0] got;
      if (reset) begin
         kp        = '0;
         ki        = '0;
         kd        = '0;
         out_lim   = pidc_pkg::DRIVE_LIMIT_RESET;
         integ_lim = pidc_pkg::ACCUM_LIMIT_RESET;
         integ     = '0;
         prev_err  = '0;
         expected_drives.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               pidc_pkg::REG_GAIN_P:      kp        = csr_data[pidc_pkg::GAIN_WIDTH-1:0];
               pidc_pkg::REG_GAIN_I:      ki        = csr_data[pidc_pkg::GAIN_WIDTH-1:0];
               pidc_pkg::REG_GAIN_D:      kd        = csr_data[pidc_pkg::GAIN_WIDTH-1:0];
               pidc_pkg::REG_DRIVE_LIMIT:
                  out_lim = csr_data[pidc_pkg::DRIVE_LIMIT_WIDTH-1:0];
               pidc_pkg::REG_ACCUM_LIMIT:
                  integ_lim = csr_data[pidc_pkg::ACCUM_LIMIT_WIDTH-1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            rsp_seen++;
            got = rsp_tdata[SAMPLE_WIDTH-1:0];
            if (expected_drives.size() == 0) begin
               report_mismatch($sformatf("response with nothing pending, drive %0d clamped %0b",
                                         got, rsp_tuser));
            end else begin
               want = expected_drives.pop_front();
               if (got !== want.drive)
                  report_mismatch($sformatf("drive %0d, expected %0d", got, want.drive));
               if (rsp_tuser !== want.clamped)
                  report_mismatch($sformatf("clamped %0b, expected %0b (drive %0d)",
                                            rsp_tuser, want.clamped, want.drive));
            end
         end
         if (req_tvalid && req_tready)
            advance_regulator(req_tuser, req_tdata[SAMPLE_WIDTH-1:0],
                              req_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]);
      end
   end

endmodule

[tb/pid_controller_clamped_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_controller_clamped_top_tb
// drives directed and random regulator requests and register settings into
// the clamped pid block, the random ones partly under stalls on both sides;
// a checker beside the block predicts every response and counts mismatches
// ----------------------------------------------------------------------------
module pid_controller_clamped_top_tb;

   localparam int SAMPLE_WIDTH    = 16;
   localparam int GAIN_FRAC_BITS  = 8;
   localparam int CLOCK_PERIOD    = 10;
   localparam int RESET_CYCLES    = 4;
   localparam int RANDOM_BLOCKS   = 12;
   localparam int ITEMS_PER_BLOCK = 128;
   localparam int DRAIN_CYCLES    = 12;   // four pipeline stages plus margin
   localparam int RUN_LIMIT_NS    = 2_000_000;

   // field widths of the register map
   localparam int GAIN_BITS  = pidc_pkg::GAIN_WIDTH;
   localparam int DLIM_BITS  = pidc_pkg::DRIVE_LIMIT_WIDTH;
   localparam int ALIM_BITS  = pidc_pkg::ACCUM_LIMIT_WIDTH;
   localparam int INDEX_BITS = pidc_pkg::CSR_INDEX_WIDTH;
   localparam int DATA_BITS  = pidc_pkg::CSR_DATA_WIDTH;

   // register indexes past the end of the map, writes there are dropped
   localparam logic [INDEX_BITS-1:0] REG_SPARE_FIRST = 3'd5;
   localparam logic [INDEX_BITS-1:0] REG_SPARE_LAST  = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // request side, all driven from time zero
   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] req_tdata  = '0;   // target, feedback, zero pad
   logic                                req_tuser  = pidc_pkg::OP_COMPUTE;  // operation

   // response side
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   rsp_tdata;   // drive, zero pad
   logic                                rsp_tuser;   // clamped

   // register write channel
   logic                                csr_valid = 1'b0;
   logic                                csr_ready;
   logic [INDEX_BITS-1:0]               csr_index = pidc_pkg::REG_GAIN_P;
   logic [DATA_BITS-1:0]                csr_data  = '0;

   // stall rates in percent, changed per phase
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   int requests_sent = 0;
   int check_fails;
   int rsp_seen;

   logic [SAMPLE_WIDTH-1:0] corners [4] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   pid_controller_clamped_top #(
      .SAMPLE_WIDTH   (SAMPLE_WIDTH),
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   pid_controller_clamped_checker #(
      .SAMPLE_WIDTH   (SAMPLE_WIDTH),
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .fail_count (check_fails),
      .rsp_seen   (rsp_seen)
   );

   // receiver back-pressure, redrawn every cycle
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // one request; may idle first, returns at the accepting edge
   task automatic push_request(input logic op, input logic [SAMPLE_WIDTH-1:0] tgt,
                               input logic [SAMPLE_WIDTH-1:0] fb);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {fb, tgt};
      do @(posedge clock); while (!req_tready);
      requests_sent++;
   endtask

   // stop sending and wait until every request has its response
   task automatic settle();
      req_tvalid <= 1'b0;
      while (rsp_seen != requests_sent) @(posedge clock);
   endtask

   // register write; csr_valid stays high for a following write
   task automatic write_reg(input logic [INDEX_BITS-1:0] idx,
                            input logic [DATA_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   // full register set, led by a write to an unmapped index
   task automatic write_config(input logic [GAIN_BITS-1:0] p_gain,
                               input logic [GAIN_BITS-1:0] i_gain,
                               input logic [GAIN_BITS-1:0] d_gain,
                               input logic [DLIM_BITS-1:0] d_lim,
                               input logic [ALIM_BITS-1:0] a_lim);
      write_reg($urandom_range(1) ? REG_SPARE_FIRST : REG_SPARE_LAST, $urandom);
      write_reg(pidc_pkg::REG_GAIN_P, DATA_BITS'(p_gain));
      write_reg(pidc_pkg::REG_GAIN_I, DATA_BITS'(i_gain));
      write_reg(pidc_pkg::REG_GAIN_D, DATA_BITS'(d_gain));
      write_reg(pidc_pkg::REG_DRIVE_LIMIT, DATA_BITS'(d_lim));
      write_reg(pidc_pkg::REG_ACCUM_LIMIT, DATA_BITS'(a_lim));
      csr_valid <= 1'b0;
   endtask

   // gains: mostly moderate so the output is not pinned at the limit
   function automatic logic [GAIN_BITS-1:0] pick_gain();
      case ($urandom_range(3))
         0:       return GAIN_BITS'($urandom_range(0, 511));
         1:       return GAIN_BITS'($urandom_range(0, 4095));
         2:       return GAIN_BITS'($urandom);
         default: return $urandom_range(1) ? '1 : '0;
      endcase
   endfunction

   initial begin
      logic [GAIN_BITS-1:0]    p_gain, i_gain, d_gain;
      logic [DLIM_BITS-1:0]    d_lim;
      logic [ALIM_BITS-1:0]    a_lim;
      logic                    op;
      logic [SAMPLE_WIDTH-1:0] tgt, fb;
      int                      pick;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // reset register values: zero gains, full limits
      push_request(pidc_pkg::OP_COMPUTE, 16'h0000, 16'h0000);
      push_request(pidc_pkg::OP_COMPUTE, 16'h7FFF, 16'h8000);
      settle();

      // largest errors both ways against moderate limits, clear in between
      write_config(16'h0100, 16'h0010, 16'h0080, 15'd1000, 31'd5000);
      push_request(pidc_pkg::OP_CLEAR, 16'h1234, 16'hFEDC);
      push_request(pidc_pkg::OP_COMPUTE, 16'h7FFF, 16'h8000);
      push_request(pidc_pkg::OP_COMPUTE, 16'h8000, 16'h7FFF);
      push_request(pidc_pkg::OP_COMPUTE, 16'h0000, 16'h0000);
      push_request(pidc_pkg::OP_CLEAR, 16'hFFFF, 16'hFFFF);
      push_request(pidc_pkg::OP_COMPUTE, 16'h0000, 16'h0000);
      settle();

      // proportional only, gain 1.5: output exactly at the limit passes
      // unflagged, one past it is limited, negative halves round down
      write_config(16'h0180, 16'h0000, 16'h0000, 15'd999, pidc_pkg::ACCUM_LIMIT_RESET);
      push_request(pidc_pkg::OP_COMPUTE, 16'd666, 16'd0);
      push_request(pidc_pkg::OP_COMPUTE, -16'sd666, 16'd0);
      push_request(pidc_pkg::OP_COMPUTE, 16'd667, 16'd0);
      push_request(pidc_pkg::OP_COMPUTE, -16'sd667, 16'd0);
      push_request(pidc_pkg::OP_COMPUTE, 16'hFFFF, 16'd0);
      settle();

      // zero limits with full gains: drive held at zero, flagged when nonzero
      write_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 15'd0, 31'd0);
      push_request(pidc_pkg::OP_COMPUTE, 16'd0, 16'd0);
      push_request(pidc_pkg::OP_COMPUTE, 16'd5, 16'd3);
      push_request(pidc_pkg::OP_COMPUTE, 16'h8000, 16'h7FFF);
      settle();

      // wind the integral up, then lower its limit: next sample pulls it in
      write_config(16'h0000, 16'h0100, 16'h0000, pidc_pkg::DRIVE_LIMIT_RESET,
                   pidc_pkg::ACCUM_LIMIT_RESET);
      push_request(pidc_pkg::OP_CLEAR, 16'h0000, 16'h0000);
      repeat (3) push_request(pidc_pkg::OP_COMPUTE, 16'h7FFF, 16'h8000);
      settle();
      write_config(16'h0000, 16'h0100, 16'h0000, pidc_pkg::DRIVE_LIMIT_RESET, 31'd100);
      push_request(pidc_pkg::OP_COMPUTE, 16'h0000, 16'h0000);
      push_request(pidc_pkg::OP_CLEAR, 16'h0000, 16'h0000);
      settle();

      // random blocks, each under a fresh register setting;
      // stall mix per third: sender light and receiver heavy, swapped, none
      for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
         case (blk / (RANDOM_BLOCKS / 3))
            0:       begin send_idle_pct = 7;  recv_idle_pct = 59; end
            1:       begin send_idle_pct = 59; recv_idle_pct = 7;  end
            default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
         endcase

         p_gain = pick_gain();
         i_gain = pick_gain();
         d_gain = pick_gain();
         pick   = $urandom_range(9);
         if (pick == 0)
            d_lim = '0;
         else if (pick < 4)
            d_lim = pidc_pkg::DRIVE_LIMIT_RESET;
         else if (pick < 7)
            d_lim = DLIM_BITS'($urandom_range(0, 2000));
         else
            d_lim = DLIM_BITS'($urandom);
         pick = $urandom_range(9);
         if (pick == 0)
            a_lim = '0;
         else if (pick == 1)
            a_lim = pidc_pkg::ACCUM_LIMIT_RESET;
         else if (pick < 6)
            a_lim = ALIM_BITS'($urandom_range(0, 50000));
         else
            a_lim = ALIM_BITS'($urandom);
         write_config(p_gain, i_gain, d_gain, d_lim, a_lim);

         for (int n = 0; n < ITEMS_PER_BLOCK; n++) begin
            op = ($urandom_range(99) < 4) ? pidc_pkg::OP_CLEAR : pidc_pkg::OP_COMPUTE;
            case ($urandom_range(3))
               0: begin
                  tgt = SAMPLE_WIDTH'($urandom);
                  fb  = SAMPLE_WIDTH'($urandom);
               end
               1: begin
                  // measurement tracking the setpoint, small error
                  tgt = SAMPLE_WIDTH'($urandom);
                  fb  = tgt - SAMPLE_WIDTH'($urandom_range(0, 128)) + 16'd64;
               end
               2: begin
                  tgt = SAMPLE_WIDTH'($urandom_range(0, 1023)) - 16'd512;
                  fb  = SAMPLE_WIDTH'($urandom_range(0, 1023)) - 16'd512;
               end
               default: begin
                  tgt = corners[$urandom_range(3)];
                  fb  = corners[$urandom_range(3)];
               end
            endcase
            push_request(op, tgt, fb);
         end
         settle();
      end

      // let any stray response show up before the verdict
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (check_fails == 0)
         $display("pid_controller_clamped_top_tb OK");
      else
         $display("pid_controller_clamped_top_tb NOT OK");
      $finish;
   end

   // hang guard
   initial begin
      #(RUN_LIMIT_NS);
      $display("pid_controller_clamped_top_tb NOT OK");
      $finish;
   end

endmodule
